// ===== design/signed_binary_to_decimal_ascii_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed binary to decimal ASCII converter
// Shared property templates, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication.
`define SBDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg
// Widths, character codes and shared types of the decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbda_pkg;

  localparam int ValueWidth  = 64;
  localparam int CharWidth   = 7;
  localparam int NumDigits   = 20;
  localparam int BcdWidth    = 4 * NumDigits;
  localparam int CntWidth    = $clog2(ValueWidth + 1);
  localparam int DigCntWidth = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0] CharZero  = 7'd48;
  localparam logic [CharWidth-1:0] CharMinus = 7'd45;

  // Sequencer states of the character emitter.
  typedef enum logic [1:0] {
    StIdle,
    StSkip,
    StSign,
    StDigit
  } emit_state_e;

  // Status of the binary to BCD shifter.
  typedef struct packed {
    logic busy;
    logic done;
  } dab_stat_t;

endpackage

`default_nettype wire

// ===== design/sbda_dabble.sv =====
// ----------------------------------------------------------------------------
// sbda_dabble
// Bit-serial binary to BCD conversion, one magnitude bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_dabble (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               load_i,
  input  wire logic [sbda_pkg::ValueWidth-1:0]    mag_i,
  output sbda_pkg::dab_stat_t                     stat_o,
  output logic [sbda_pkg::BcdWidth-1:0]           bcd_o
);

  logic [sbda_pkg::ValueWidth-1:0] mag_q, mag_d;
  logic [sbda_pkg::BcdWidth-1:0]   bcd_q, bcd_d;
  logic [sbda_pkg::BcdWidth-1:0]   bcd_adj;
  logic [sbda_pkg::CntWidth-1:0]   cnt_q, cnt_d;
  logic                            done_q, done_d;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < sbda_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Load the magnitude, then shift it into the digits one bit per cycle.
  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (load_i) begin
      mag_d = mag_i;
      bcd_d = '0;
      cnt_d = sbda_pkg::CntWidth'(sbda_pkg::ValueWidth);
    end else if (cnt_q != '0) begin
      mag_d  = {mag_q[sbda_pkg::ValueWidth-2:0], 1'b0};
      bcd_d  = {bcd_adj[sbda_pkg::BcdWidth-2:0], mag_q[sbda_pkg::ValueWidth-1]};
      cnt_d  = cnt_q - sbda_pkg::CntWidth'(1);
      done_d = (cnt_q == sbda_pkg::CntWidth'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign bcd_o       = bcd_q;

endmodule

`default_nettype wire

// ===== design/sbda_emit.sv =====
// ----------------------------------------------------------------------------
// sbda_emit
// Skips leading zero digits and sends the sign and digits one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_emit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             load_i,
  input  wire logic                             neg_i,
  input  wire logic [sbda_pkg::BcdWidth-1:0]    bcd_i,
  output logic                                  busy_o,
  output logic                                  strobe_o,
  output logic [sbda_pkg::CharWidth-1:0]        character_o,
  output logic                                  last_o
);

  sbda_pkg::emit_state_e              state_q, state_d;
  logic [sbda_pkg::BcdWidth-1:0]      bcd_q, bcd_d;
  logic [sbda_pkg::DigCntWidth-1:0]   rem_q, rem_d;
  logic                               neg_q, neg_d;
  logic [3:0]                         top_digit;

  assign top_digit = bcd_q[sbda_pkg::BcdWidth-1 -: 4];

  // Next state and the character beat of the current cycle.
  always_comb begin
    state_d     = state_q;
    bcd_d       = bcd_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    strobe_o    = 1'b0;
    character_o = sbda_pkg::CharZero + {3'b000, top_digit};
    last_o      = 1'b0;
    case (state_q)
      sbda_pkg::StIdle: begin
        if (load_i) begin
          bcd_d   = bcd_i;
          rem_d   = sbda_pkg::DigCntWidth'(sbda_pkg::NumDigits);
          neg_d   = neg_i;
          state_d = sbda_pkg::StSkip;
        end
      end
      sbda_pkg::StSkip: begin
        // Drop leading zeros, keeping at least one digit.
        if ((top_digit == 4'd0) && (rem_q != sbda_pkg::DigCntWidth'(1))) begin
          bcd_d = {bcd_q[sbda_pkg::BcdWidth-5:0], 4'd0};
          rem_d = rem_q - sbda_pkg::DigCntWidth'(1);
        end else if (neg_q) begin
          state_d = sbda_pkg::StSign;
        end else begin
          state_d = sbda_pkg::StDigit;
        end
      end
      sbda_pkg::StSign: begin
        strobe_o    = 1'b1;
        character_o = sbda_pkg::CharMinus;
        state_d     = sbda_pkg::StDigit;
      end
      sbda_pkg::StDigit: begin
        strobe_o = 1'b1;
        last_o   = (rem_q == sbda_pkg::DigCntWidth'(1));
        bcd_d    = {bcd_q[sbda_pkg::BcdWidth-5:0], 4'd0};
        rem_d    = rem_q - sbda_pkg::DigCntWidth'(1);
        if (rem_q == sbda_pkg::DigCntWidth'(1)) begin
          state_d = sbda_pkg::StIdle;
        end
      end
      default: begin
        state_d = sbda_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbda_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign busy_o = (state_q != sbda_pkg::StIdle);

endmodule

`default_nettype wire

// ===== design/signed_binary_to_decimal_ascii.sv =====
// Sequence: the BCD converter shifts the magnitude in, the emitter skips the
//   leading zeros, then sends the sign and digits, one character per cycle.
// Intake: a new item is taken only while busy is low, after the last character;
//   busy spans the 64 bit-serial shift steps and the 20-digit scan.
// Reset: asynchronous, active low; the block comes up idle with busy low.
// Results cannot be held off: each character beat lasts exactly one cycle.
`default_nettype none
`include "signed_binary_to_decimal_ascii_defines.svh"

// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed 64-bit integer to its decimal ASCII text, one beat each.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [sbda_pkg::ValueWidth-1:0] value_i,
  output logic                                   strobe,
  output logic [sbda_pkg::CharWidth-1:0]         character_o,
  output logic                                   last_o
);

  sbda_pkg::dab_stat_t               dab_stat;
  logic [sbda_pkg::BcdWidth-1:0]     dab_bcd;
  logic [sbda_pkg::ValueWidth-1:0]   mag;
  logic                              accept;
  logic                              emit_busy;
  logic                              neg_q, neg_d;

  assign accept = start && !busy;

  // Unsigned magnitude; the most negative value maps onto 2^63.
  assign mag = value_i[sbda_pkg::ValueWidth-1] ?
               (~value_i + sbda_pkg::ValueWidth'(1)) : value_i;

  assign neg_d = accept ? value_i[sbda_pkg::ValueWidth-1] : neg_q;

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
  end

  sbda_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .mag_i  (mag),
    .stat_o (dab_stat),
    .bcd_o  (dab_bcd)
  );

  sbda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (dab_stat.done),
    .neg_i       (neg_q),
    .bcd_i       (dab_bcd),
    .busy_o      (emit_busy),
    .strobe_o    (strobe),
    .character_o (character_o),
    .last_o      (last_o)
  );

  assign busy = dab_stat.busy || dab_stat.done || emit_busy;

  // Checks on the conversion sequence.
  `SBDA_ASSERT_NOW(a_strobe_busy, strobe, busy, "character beat while idle")
  `SBDA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "item taken but block idle")
  `SBDA_ASSERT_NEXT(a_last_ends, strobe && last_o, !strobe, "beat after last character")
  `SBDA_ASSERT_NOW(a_minus_not_last, strobe && (character_o == sbda_pkg::CharMinus),
    !last_o, "minus sign flagged as last")

endmodule

`default_nettype wire
